// File: rtl/dmpt_pkg.sv
// Package for the drive mixer with piston tracker: payload structs, piston
// codes, controller states, command/status structs and shared constants.
// No dependencies.
`timescale 1ns / 1ps

package dmpt_pkg;

	// Q2.14 unity and divider geometry
	localparam int unsigned QW        = 16;
	localparam int unsigned MAGW      = QW + 1;           // |y +/- theta| up to 65536
	localparam int unsigned REMW      = MAGW + 1;         // partial remainder after shift
	localparam int unsigned QUOTW     = 15;               // quotient up to 16384
	localparam int unsigned DIV_STEPS = QUOTW;
	localparam int unsigned STEPW     = $clog2(DIV_STEPS);

	localparam logic [MAGW-1:0] Q_ONE = MAGW'(16384);

	// configuration registers
	localparam int unsigned CFG_DW = 16;
	localparam int unsigned CFG_IW = 1;
	localparam logic [CFG_IW-1:0] CFG_SETTLE_MS            = 1'b0;
	localparam logic [CFG_IW-1:0] CFG_STATIONARY_THRESHOLD = 1'b1;

	localparam logic [15:0] SETTLE_MS_RST            = 16'd200;
	localparam logic [14:0] STATIONARY_THRESHOLD_RST = 15'd1638;

	typedef enum logic [1:0] {
		PST_FULL     = 2'd0,
		PST_FILLING  = 2'd1,
		PST_EMPTY    = 2'd2,
		PST_EMPTYING = 2'd3
	} piston_t;

	typedef struct packed {
		logic        [31:0] now_ms;
		logic signed [15:0] strafe_goal;
		logic signed [15:0] forward_goal;
		logic signed [15:0] turn_goal;
	} goal_t;

	typedef struct packed {
		logic signed [15:0] left_power;
		logic signed [15:0] right_power;
		logic signed [15:0] center_power;
		logic               piston_extend;
		logic        [1:0]  piston_estimate;
	} result_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_MIX,
		S_DIV,
		S_FINISH
	} ctrl_state_t;

	typedef struct packed {
		logic capture;   // latch the accepted goal
		logic mix;       // mix, pick the piston command, seed the divider
		logic div_step;  // one restoring-division step
		logic out_load;  // move the finished result into the output register
	} ctrl_cmd_t;

	typedef struct packed {
		logic div_last;  // the current divider step is the final one
	} dp_status_t;

endpackage

// File: rtl/dmpt_if.sv
// Valid/ready channel interfaces for goal transactions and result transactions.
// Depends on dmpt_pkg.
`timescale 1ns / 1ps

interface dmpt_goal_if;
	logic            valid;
	logic            ready;
	dmpt_pkg::goal_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

interface dmpt_result_if;
	logic              valid;
	logic              ready;
	dmpt_pkg::result_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/drive_mixer_with_piston_tracker.sv
// Top level of the drive mixer with piston tracker: goal and result channels,
// configuration write port. Depends on dmpt_pkg, dmpt_if, dmpt_ctrl, dmpt_datapath.
`timescale 1ns / 1ps

// Takes one goal transaction (strafe, forward, turn in Q2.14 plus a ms timestamp)
// at a time and returns exactly one result transaction for it. Left and right
// wheel power are (forward +/- turn) scaled by 16384 / max(1.0, |left|, |right|),
// truncated toward zero; center power is the strafe goal unchanged. The strafe
// piston extends when 2*|strafe| >= max(|left|, |right|), except when every
// magnitude is below stationary_threshold, where it keeps the direction of the
// current piston estimate. The estimate (0 full, 1 filling, 2 empty,
// 3 emptying) resets to emptying with a change time of 0 and turns full/empty
// once settle_ms have passed since the last command change.
// Timing: a goal is accepted in the idle cycle, mixed in the next, then a
// shared 15-step restoring divider produces both wheel quotients one bit per
// cycle, and the finish state loads the output register once the output is
// free or being read, so a stalled receiver holds the block there. The next
// goal may be taken while that result still waits on the output.
// Configuration: index 0 settle_ms, index 1 stationary_threshold; write only
// while no goal is in flight.

module drive_mixer_with_piston_tracker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [dmpt_pkg::CFG_IW-1:0]  cfg_index,
	input  logic [dmpt_pkg::CFG_DW-1:0]  cfg_wdata,
	dmpt_goal_if.sink                    goal,
	dmpt_result_if.source                result
);

	dmpt_pkg::ctrl_cmd_t  cmd;
	dmpt_pkg::dp_status_t status;

	// sequencer: owns the handshakes and the output-register valid flag
	dmpt_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.goal_valid   (goal.valid),
		.goal_ready   (goal.ready),
		.result_valid (result.valid),
		.result_ready (result.ready),
		.status       (status),
		.cmd          (cmd)
	);

	// arithmetic, piston tracker, config registers and result payload
	dmpt_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.goal      (goal.payload),
		.cmd       (cmd),
		.status    (status),
		.result    (result.payload)
	);

`ifndef SYNTHESIS
	// one goal at a time: no transaction is taken in the cycle after one was
	a_single_goal: assert property (@(posedge clk) disable iff (!arst_n)
		goal.valid && goal.ready |=> !goal.ready)
		else $error("goal accepted back to back");

	// normalized wheel powers stay within [-1.0, 1.0]
	a_power_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.payload.left_power <= 16'sd16384)
			&& (result.payload.left_power >= -16'sd16384)
			&& (result.payload.right_power <= 16'sd16384)
			&& (result.payload.right_power >= -16'sd16384))
		else $error("wheel power out of range");

	// estimate follows the command: full/filling exactly when extended
	a_estimate_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.payload.piston_extend ==
			((result.payload.piston_estimate == dmpt_pkg::PST_FULL)
			|| (result.payload.piston_estimate == dmpt_pkg::PST_FILLING))))
		else $error("piston estimate disagrees with command");
`endif

endmodule

// File: rtl/dmpt_ctrl.sv
// Controller state machine: sequences capture, mix, division and result hand-off.
// Depends on dmpt_pkg.
`timescale 1ns / 1ps

module dmpt_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   goal_valid,
	output logic                   goal_ready,
	output logic                   result_valid,
	input  logic                   result_ready,
	input  dmpt_pkg::dp_status_t   status,
	output dmpt_pkg::ctrl_cmd_t    cmd
);

	dmpt_pkg::ctrl_state_t state_q, state_nxt;
	logic                  out_valid_q;
	logic                  slot_free;

	assign slot_free    = !out_valid_q || result_ready;
	assign result_valid = out_valid_q;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			dmpt_pkg::S_IDLE: begin
				if (goal_valid) state_nxt = dmpt_pkg::S_MIX;
			end
			dmpt_pkg::S_MIX: begin
				state_nxt = dmpt_pkg::S_DIV;
			end
			dmpt_pkg::S_DIV: begin
				if (status.div_last) state_nxt = dmpt_pkg::S_FINISH;
			end
			dmpt_pkg::S_FINISH: begin
				if (slot_free) state_nxt = dmpt_pkg::S_IDLE;
			end
			default: begin
				state_nxt = dmpt_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd        = '0;
		goal_ready = 1'b0;
		unique case (state_q)
			dmpt_pkg::S_IDLE: begin
				goal_ready  = 1'b1;
				cmd.capture = goal_valid;
			end
			dmpt_pkg::S_MIX: begin
				cmd.mix = 1'b1;
			end
			dmpt_pkg::S_DIV: begin
				cmd.div_step = 1'b1;
			end
			dmpt_pkg::S_FINISH: begin
				cmd.out_load = slot_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dmpt_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: rtl/dmpt_datapath.sv
// Datapath: goal capture, arcade mixing, piston tracker, shared restoring divider
// for both wheels and the output register. Depends on dmpt_pkg.
`timescale 1ns / 1ps

module dmpt_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [dmpt_pkg::CFG_IW-1:0]          cfg_index,
	input  logic [dmpt_pkg::CFG_DW-1:0]          cfg_wdata,
	input  dmpt_pkg::goal_t                      goal,
	input  dmpt_pkg::ctrl_cmd_t                  cmd,
	output dmpt_pkg::dp_status_t                 status,
	output dmpt_pkg::result_t                    result
);

	localparam int unsigned MAGW  = dmpt_pkg::MAGW;
	localparam int unsigned REMW  = dmpt_pkg::REMW;
	localparam int unsigned QUOTW = dmpt_pkg::QUOTW;
	localparam int unsigned STEPW = dmpt_pkg::STEPW;

	// configuration
	logic [15:0] settle_q;
	logic [14:0] thresh_q;

	// piston tracker
	dmpt_pkg::piston_t piston_q;
	logic              last_cmd_q;
	logic [31:0]       change_q;

	// captured goal
	logic        [31:0] now_q;
	logic signed [15:0] x_q, y_q, th_q;

	// divider
	logic [MAGW-1:0]  divisor_q;
	logic [REMW-1:0]  rem_l_q, rem_r_q;
	logic [QUOTW-1:0] quot_l_q, quot_r_q;
	logic             neg_l_q, neg_r_q;
	logic [STEPW-1:0] step_q;
	logic             ext_q;
	logic signed [15:0] center_q;
	dmpt_pkg::result_t result_q;

	// mix logic
	logic signed [MAGW-1:0] l_sum, r_sum;
	logic [MAGW-1:0] mag_l, mag_r, mag_x, main_mag, div_m, biggest;
	logic            stationary, hold_ext, cmd_bit, settled;
	logic [31:0]     elapsed;
	dmpt_pkg::piston_t piston_nxt;

	// divide step
	logic [REMW-1:0] trial_l, trial_r;
	logic            ge_l, ge_r;

	assign l_sum = MAGW'(y_q) + MAGW'(th_q);
	assign r_sum = MAGW'(y_q) - MAGW'(th_q);

	assign mag_l = l_sum[MAGW-1] ? MAGW'(-l_sum) : MAGW'(l_sum);
	assign mag_r = r_sum[MAGW-1] ? MAGW'(-r_sum) : MAGW'(r_sum);
	assign mag_x = x_q[15] ? MAGW'(-MAGW'(x_q)) : MAGW'(x_q);

	assign main_mag = (mag_l > mag_r) ? mag_l : mag_r;
	assign div_m    = (main_mag > dmpt_pkg::Q_ONE) ? main_mag : dmpt_pkg::Q_ONE;
	assign biggest  = (main_mag > mag_x) ? main_mag : mag_x;

	assign stationary = biggest < MAGW'(thresh_q);
	assign hold_ext   = (piston_q == dmpt_pkg::PST_FULL) || (piston_q == dmpt_pkg::PST_FILLING);
	assign cmd_bit    = stationary ? hold_ext : ({mag_x, 1'b0} >= {1'b0, main_mag});

	assign elapsed = now_q - change_q;
	assign settled = elapsed >= {16'd0, settle_q};

	always_comb begin
		piston_nxt = piston_q;
		if (cmd_bit == last_cmd_q) begin
			if (settled) piston_nxt = last_cmd_q ? dmpt_pkg::PST_FULL : dmpt_pkg::PST_EMPTY;
		end else begin
			piston_nxt = cmd_bit ? dmpt_pkg::PST_FILLING : dmpt_pkg::PST_EMPTYING;
		end
	end

	// first step compares the magnitude itself, later steps shift in a zero
	assign trial_l = (step_q == '0) ? rem_l_q : {rem_l_q[REMW-2:0], 1'b0};
	assign trial_r = (step_q == '0) ? rem_r_q : {rem_r_q[REMW-2:0], 1'b0};
	assign ge_l    = trial_l >= {1'b0, divisor_q};
	assign ge_r    = trial_r >= {1'b0, divisor_q};

	assign status.div_last = (step_q == STEPW'(dmpt_pkg::DIV_STEPS - 1));
	assign result          = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q   <= dmpt_pkg::SETTLE_MS_RST;
			thresh_q   <= dmpt_pkg::STATIONARY_THRESHOLD_RST;
			piston_q   <= dmpt_pkg::PST_EMPTYING;
			last_cmd_q <= 1'b0;
			change_q   <= '0;
			step_q     <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					dmpt_pkg::CFG_SETTLE_MS:            settle_q <= cfg_wdata;
					dmpt_pkg::CFG_STATIONARY_THRESHOLD: thresh_q <= cfg_wdata[14:0];
					default:                            settle_q <= settle_q;
				endcase
			end
			if (cmd.mix) begin
				piston_q <= piston_nxt;
				step_q   <= '0;
				if (cmd_bit != last_cmd_q) begin
					last_cmd_q <= cmd_bit;
					change_q   <= now_q;
				end
			end else if (cmd.div_step) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			now_q <= goal.now_ms;
			x_q   <= goal.strafe_goal;
			y_q   <= goal.forward_goal;
			th_q  <= goal.turn_goal;
		end
		if (cmd.mix) begin
			divisor_q <= div_m;
			rem_l_q   <= REMW'(mag_l);
			rem_r_q   <= REMW'(mag_r);
			neg_l_q   <= l_sum[MAGW-1];
			neg_r_q   <= r_sum[MAGW-1];
			quot_l_q  <= '0;
			quot_r_q  <= '0;
			ext_q     <= cmd_bit;
			center_q  <= x_q;
		end else if (cmd.div_step) begin
			rem_l_q  <= ge_l ? (trial_l - REMW'(divisor_q)) : trial_l;
			rem_r_q  <= ge_r ? (trial_r - REMW'(divisor_q)) : trial_r;
			quot_l_q <= {quot_l_q[QUOTW-2:0], ge_l};
			quot_r_q <= {quot_r_q[QUOTW-2:0], ge_r};
		end
		if (cmd.out_load) begin
			result_q.left_power  <= neg_l_q ? -$signed({1'b0, quot_l_q})
			                                :  $signed({1'b0, quot_l_q});
			result_q.right_power <= neg_r_q ? -$signed({1'b0, quot_r_q})
			                                :  $signed({1'b0, quot_r_q});
			result_q.center_power    <= center_q;
			result_q.piston_extend   <= ext_q;
			result_q.piston_estimate <= piston_q;
		end
	end

endmodule

// File: dv/testbench.sv
// Testbench for drive_mixer_with_piston_tracker: drives goal transactions
// through the valid/ready channels, predicts each result with a class-based
// scoreboard (wheel mix, normalization, piston tracker). Depends on dmpt_pkg and dmpt_if.
`timescale 1ns / 1ps

module testbench;
	import dmpt_pkg::*;

	localparam int HALF_PERIOD  = 5;
	localparam int DRAIN_SLACK  = 24;
	localparam int PHASE_ITEMS  = 305;
	localparam int RUN_LIMIT_NS = 10_000_000;  // far above the slowest clean run

	// Scoreboard: own copy of registers and piston tracker, queue of due results
	class mixer_scoreboard;
		result_t     due_results[$];
		int          errors;
		logic [15:0] settle;
		logic [14:0] threshold;
		piston_t     estimate;
		logic        last_cmd;
		logic [31:0] changed_at;

		function new();
			errors     = 0;
			settle     = SETTLE_MS_RST;
			threshold  = STATIONARY_THRESHOLD_RST;
			estimate   = PST_EMPTYING;
			last_cmd   = 1'b0;
			changed_at = '0;
		endfunction

		function void write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
			if (idx == CFG_SETTLE_MS)
				settle = data;
			else if (idx == CFG_STATIONARY_THRESHOLD)
				threshold = data[14:0];
		endfunction

		// trunc(v * 1.0 / m) in Q2.14, truncated toward zero
		function logic [15:0] scale(longint v, longint m);
			longint q;
			q = ((v < 0) ? -v : v) * 16384 / m;
			if (v < 0)
				q = -q;
			return q[15:0];
		endfunction

		function result_t mix_and_track(goal_t g);
			longint      l, r, al, ar, ax, main_mag, m, big;
			logic        cmd;
			logic [31:0] elapsed;
			result_t     res;
			l        = longint'($signed(g.forward_goal)) + longint'($signed(g.turn_goal));
			r        = longint'($signed(g.forward_goal)) - longint'($signed(g.turn_goal));
			al       = (l < 0) ? -l : l;
			ar       = (r < 0) ? -r : r;
			ax       = longint'($signed(g.strafe_goal));
			ax       = (ax < 0) ? -ax : ax;
			main_mag = (al > ar) ? al : ar;
			m        = (main_mag > 16384) ? main_mag : 16384;
			big      = (main_mag > ax) ? main_mag : ax;
			if (big < longint'(threshold))
				cmd = (estimate == PST_FULL || estimate == PST_FILLING);
			else
				cmd = (2 * ax >= main_mag);
			if (cmd == last_cmd) begin
				elapsed = g.now_ms - changed_at;
				if (elapsed >= {16'd0, settle})
					estimate = last_cmd ? PST_FULL : PST_EMPTY;
			end else begin
				estimate   = cmd ? PST_FILLING : PST_EMPTYING;
				last_cmd   = cmd;
				changed_at = g.now_ms;
			end
			res.left_power      = scale(l, m);
			res.right_power     = scale(r, m);
			res.center_power    = g.strafe_goal;
			res.piston_extend   = cmd;
			res.piston_estimate = estimate;
			return res;
		endfunction

		function void note_goal(goal_t g);
			due_results.push_back(mix_and_track(g));
		endfunction

		function int pending();
			return due_results.size();
		endfunction

		task report(string msg);
			$display("ERROR @%0t: %s", $time, msg);
			errors++;
		endtask

		task check_result(result_t got);
			result_t want;
			if (due_results.size() == 0) begin
				report("result transaction with nothing due");
				return;
			end
			want = due_results.pop_front();
			if (got.left_power !== want.left_power)
				report($sformatf("left_power %0d, due %0d",
					$signed(got.left_power), $signed(want.left_power)));
			if (got.right_power !== want.right_power)
				report($sformatf("right_power %0d, due %0d",
					$signed(got.right_power), $signed(want.right_power)));
			if (got.center_power !== want.center_power)
				report($sformatf("center_power %0d, due %0d",
					$signed(got.center_power), $signed(want.center_power)));
			if (got.piston_extend !== want.piston_extend)
				report($sformatf("piston_extend %0b, due %0b",
					got.piston_extend, want.piston_extend));
			if (got.piston_estimate !== want.piston_estimate)
				report($sformatf("piston_estimate %0d, due %0d",
					got.piston_estimate, want.piston_estimate));
		endtask

		task close_out();
			if (due_results.size() != 0)
				report($sformatf("%0d result transactions never arrived", due_results.size()));
		endtask
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	logic [CFG_IW-1:0]   cfg_index;
	logic [CFG_DW-1:0]   cfg_wdata;

	dmpt_goal_if   goal_ch ();
	dmpt_result_if result_ch ();

	mixer_scoreboard sb = new();

	// Timestamp generator and the register values the stimulus shapes itself on
	logic [31:0] clock_ms;
	int          cur_settle;
	int          cur_thr;
	int          tx_burst;

	// Receiver stall pattern state
	int          rx_mode;
	int          rx_left;
	int          rx_tick;
	int          rx_hold;
	logic        rx_level;

	drive_mixer_with_piston_tracker uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.goal      (goal_ch),
		.result    (result_ch)
	);

	always #HALF_PERIOD clk = ~clk;

	// Hard stop: a hung handshake ends the run as a failure
	initial begin
		#(RUN_LIMIT_NS);
		$display("drive_mixer_with_piston_tracker verification failed");
		$finish;
	end

	// Check every result transaction against the oldest due result
	always @(posedge clk) begin
		if (result_ch.valid && result_ch.ready)
			sb.check_result(result_ch.payload);
	end

	// Receiver: switch between always ready, coin flips, a fixed 3-of-7 stall
	// pattern and long stalls, each for a random stretch of cycles
	initial begin
		rx_left  = 0;
		rx_tick  = 0;
		rx_hold  = 0;
		rx_level = 1'b0;
		rx_mode  = 0;
	end

	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_left = $urandom_range(50, 300);
		end
		rx_left--;
		rx_tick++;
		case (rx_mode)
			0: result_ch.ready <= 1'b1;
			1: result_ch.ready <= 1'($urandom_range(0, 1));
			2: result_ch.ready <= ((rx_tick % 7) >= 3);
			default: begin
				if (rx_hold == 0) begin
					rx_level = ~rx_level;
					rx_hold  = rx_level ? $urandom_range(1, 5) : $urandom_range(5, 30);
				end
				rx_hold--;
				result_ch.ready <= rx_level;
			end
		endcase
	end

	// Present one goal at the falling edge and hold it until it is taken
	task send_goal(goal_t g);
		@(negedge clk);
		goal_ch.valid   <= 1'b1;
		goal_ch.payload <= g;
		do @(posedge clk); while (!goal_ch.ready);
		sb.note_goal(g);
	endtask

	// Sender bursts: count down the burst, then drop valid for a random gap
	task pace_sender();
		int gap;
		if (tx_burst > 0) begin
			tx_burst--;
		end else begin
			gap = $urandom_range(1, 12);
			@(negedge clk);
			goal_ch.valid   <= 1'b0;
			goal_ch.payload <= 80'({$urandom(), $urandom(), $urandom()});
			repeat (gap - 1) @(negedge clk);
			// now and then a long stretch with no idling at all
			tx_burst = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
				: $urandom_range(1, 16);
		end
	endtask

	// Hold off the sender until every due result has come back, then let
	// the block finish whatever is left in its pipeline
	task drain_results();
		@(negedge clk);
		goal_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_SLACK) @(posedge clk);
	endtask

	task write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_SETTLE_MS)
			cur_settle = int'(data);
		else
			cur_thr = int'(data[14:0]);
	endtask

	task send_fields(logic [31:0] t, int x, int y, int th);
		goal_t g;
		g.now_ms       = t;
		g.strafe_goal  = 16'(x);
		g.forward_goal = 16'(y);
		g.turn_goal    = 16'(th);
		pace_sender();
		send_goal(g);
	endtask

	function int pick_extreme();
		case ($urandom_range(0, 4))
			0: return -32768;
			1: return -1;
			2: return 0;
			3: return 1;
			default: return 32767;
		endcase
	endfunction

	// Advance the timestamp: mostly small steps, often right around the
	// settle time, sometimes a jump anywhere (wrap included)
	task next_goal(output goal_t g);
		int delta;
		int x, y, th, lim, mag;
		delta = 0;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: delta = $urandom_range(0, 50);
			4, 5: begin
				delta = cur_settle + int'($urandom_range(0, 4)) - 2;
				if (delta < 0)
					delta = 0;
			end
			6: delta = $urandom_range(0, 2 * cur_settle + 1);
			7: clock_ms = $urandom();
			8: delta = 0;
			default: delta = $urandom_range(0, 4000);
		endcase
		clock_ms = clock_ms + 32'(delta);

		case ($urandom_range(0, 9))
			// near-stationary goals around the threshold
			0, 1, 2: begin
				lim = cur_thr + 64;
				if (lim > 32767)
					lim = 32767;
				x  = int'($urandom_range(0, 2 * lim)) - lim;
				y  = int'($urandom_range(0, lim)) - lim / 2;
				th = int'($urandom_range(0, lim)) - lim / 2;
			end
			3, 4, 5, 6: begin
				x  = int'($urandom_range(0, 65535)) - 32768;
				y  = int'($urandom_range(0, 65535)) - 32768;
				th = int'($urandom_range(0, 65535)) - 32768;
			end
			7: begin
				x  = pick_extreme();
				y  = pick_extreme();
				th = pick_extreme();
			end
			// strafe right at half the main-wheel magnitude
			default: begin
				y   = int'($urandom_range(0, 65535)) - 32768;
				th  = int'($urandom_range(0, 65535)) - 32768;
				mag = ((y + th) < 0) ? -(y + th) : (y + th);
				if (((y - th) < 0 ? -(y - th) : (y - th)) > mag)
					mag = (y - th) < 0 ? -(y - th) : (y - th);
				x = (mag + 1) / 2 + int'($urandom_range(0, 2)) - 1;
				if (x < 0)
					x = 0;
				if (x > 32768)
					x = 32768;
				if ($urandom_range(0, 1))
					x = -x;
				else if (x > 32767)
					x = 32767;
			end
		endcase
		g.now_ms       = clock_ms;
		g.strafe_goal  = 16'(x);
		g.forward_goal = 16'(y);
		g.turn_goal    = 16'(th);
	endtask

	// One setting of the registers, then a run of random goals; optionally
	// pause mid-way until every due result is back
	task run_phase(logic [15:0] settle_word, logic [15:0] thr_word, int count, int pause_at);
		goal_t g;
		drain_results();
		write_reg(CFG_STATIONARY_THRESHOLD, thr_word);
		write_reg(CFG_SETTLE_MS, settle_word);
		for (int i = 0; i < count; i++) begin
			if (i == pause_at)
				drain_results();
			pace_sender();
			next_goal(g);
			send_goal(g);
		end
	endtask

	initial begin
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_index         = '0;
		cfg_wdata         = '0;
		goal_ch.valid     = 1'b0;
		goal_ch.payload   = '0;
		result_ch.ready   = 1'b0;
		clock_ms          = '0;
		cur_settle        = int'(SETTLE_MS_RST);
		cur_thr           = int'(STATIONARY_THRESHOLD_RST);
		tx_burst          = 0;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part, reset register values (settle 200, threshold 1638)
		send_fields(0, 0, 0, 0);                       // hold retract while still emptying
		send_fields(250, 0, 0, 0);                     // settles to empty
		send_fields(260, 16384, 0, 0);                 // strafe alone extends: filling
		send_fields(300, 32767, 32767, 32767);         // left at full scale, unsettled
		send_fields(460, -32768, -32768, -32768);      // settle time exactly: full
		send_fields(470, 0, -32768, 32767);            // retract: emptying
		send_fields(480, 100, -50, 20);                // stationary, hold retract
		send_fields(490, 0, 16384, 16384);
		send_fields(500, 1637, 0, 0);                  // just under the threshold
		send_fields(510, 1638, 0, 0);                  // at the threshold: extend
		send_fields(520, -300, 200, -100);             // stationary, hold extend (filling)
		send_fields(800, 0, 0, 0);                     // settled full, still holding
		send_fields(32'hFFFF_FF00, 0, 5000, 1000);     // retract just before the wrap
		send_fields(32'h0000_0010, 0, 5000, 1000);     // elapsed across the wrap: empty
		send_fields(32'h0000_0020, 0, 32767, -32768);
		send_fields(32'h0000_0030, 0, 16384, 0);       // divisor exactly 1.0
		send_fields(32'h0000_0040, 0, 8000, 3);
		send_fields(32'h0000_0050, 0, 20000, -7);      // truncation, positive
		send_fields(32'h0000_0060, 0, -20001, 7);      // truncation toward zero, negative
		send_fields(32'h0000_0070, -32768, 0, 0);
		send_fields(32'h0000_0080, 5000, 10000, 0);    // strafe exactly half: extend
		send_fields(32'h0000_0090, 4999, 10000, 0);    // one below half: retract
		send_fields(32'h0000_0098, 32767, -32768, -32768);
		clock_ms = 32'h0000_0100;

		// Random part across register settings, extremes first
		run_phase(16'd0, 16'd0, PHASE_ITEMS, -1);
		run_phase(16'hFFFF, 16'hFFFF, PHASE_ITEMS, -1);      // bit 15 of threshold dropped
		run_phase(16'd200, 16'd1638, PHASE_ITEMS, PHASE_ITEMS / 2);
		run_phase(16'($urandom_range(1, 600)), 16'($urandom_range(0, 65535)), PHASE_ITEMS, -1);
		run_phase(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 8000)), PHASE_ITEMS, -1);
		run_phase(16'($urandom_range(0, 40)), 16'($urandom_range(500, 4000)), PHASE_ITEMS, -1);

		// Wait out every due result plus the pipeline, then judge
		drain_results();
		sb.close_out();
		if (sb.errors == 0)
			$display("drive_mixer_with_piston_tracker verification clean");
		else
			$display("drive_mixer_with_piston_tracker verification failed");
		$finish;
	end

endmodule

// File: sim.f
rtl/dmpt_pkg.sv
rtl/dmpt_if.sv
rtl/dmpt_ctrl.sv
rtl/dmpt_datapath.sv
rtl/drive_mixer_with_piston_tracker.sv
dv/testbench.sv
